>>> rtl/ffwq_pkg.sv
// Shared constants, codes and types of the first-fit waitlist queue.
`timescale 1ns / 1ps

package ffwq_pkg;

   // Queue depth and kept id width.
   localparam int ENTRIES    = 64;
   localparam int ID_BITS    = 16;
   // Only as many id bits as the request word carries can be kept.
   localparam int ID_W       = (ID_BITS < 16) ? ID_BITS : 16;
   localparam int PFX_LEVELS = $clog2(ENTRIES);

   // Operation codes.
   localparam logic [1:0] OP_JOIN  = 2'd0;
   localparam logic [1:0] OP_LEAVE = 2'd1;
   localparam logic [1:0] OP_SEAT  = 2'd2;

   // Status codes.
   localparam logic [2:0] ST_JOINED   = 3'd0;
   localparam logic [2:0] ST_DUP      = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_LEFT     = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;
   localparam logic [2:0] ST_SEATED   = 3'd5;
   localparam logic [2:0] ST_NONEFITS = 3'd6;

   // One queue entry.
   typedef struct packed {
      logic            valid;
      logic [ID_W-1:0] id;
      logic [7:0]      size;
   } slot_type;

   // Command word held while it executes.
   typedef struct packed {
      logic [1:0]      op;
      logic [ID_W-1:0] id;
      logic [7:0]      size;
      logic [7:0]      cap;
   } cmd_type;

   // Control broadcast to every cell.
   typedef struct packed {
      cmd_type cmd;
      logic    join_en;
   } cell_ctl_type;

endpackage

>>> rtl/ffwq_if.sv
// Valid/ready channels for request and response words.
`timescale 1ns / 1ps

interface ffwq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [15:0] party_id;
   logic [7:0]  join_size;
   logic [7:0]  seat_cap;

   modport source (output valid, opcode, party_id, join_size, seat_cap, input ready);
   modport sink   (input valid, opcode, party_id, join_size, seat_cap, output ready);
endinterface

interface ffwq_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] seated_id;

   modport source (output valid, status, seated_id, input ready);
   modport sink   (input valid, status, seated_id, output ready);
endinterface

>>> rtl/first_fit_waitlist_queue.sv
// Top level of the first-fit waitlist queue.
`timescale 1ns / 1ps

// Arrival-ordered queue of up to ENTRIES requests kept packed in a row of cells, oldest in
// cell 0. Each request word is first captured into the command register; then all cells
// compare against it at once, a prefix network picks the oldest hit, and the row either
// shifts down over the removed entry or loads the new one at its tail. A new request word
// is taken only once the held one has executed, also while a finished response still
// waits in the output register; execution stalls only while that register is occupied and
// its word is not being taken. Each request word yields exactly one response word.
module first_fit_waitlist_queue (
   input  logic clock,
   input  logic reset,
   ffwq_req_if.sink   req,
   ffwq_rsp_if.source rsp
);
   import ffwq_pkg::*;

   cmd_type            cmd_ff;
   logic               cmd_valid_ff;
   logic               rsp_valid_ff;
   logic [2:0]         rsp_status_ff;
   logic [15:0]        rsp_id_ff;
   logic [2:0]         rsp_status_in;
   logic [15:0]        rsp_id_in;

   cell_ctl_type       ctl;
   slot_type           slots [ENTRIES];
   logic [ENTRIES-1:0] match;
   logic [ENTRIES-1:0] at_or_after;
   logic [ENTRIES-1:0] first;
   logic [ENTRIES-1:0] valid_vec;
   logic [ID_W-1:0]    first_id;
   logic               fire;
   logic               any_hit;
   logic               full;
   logic               removing;

   // Execute when a command is held and the response register is free or its word is being taken.
   assign fire     = cmd_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign any_hit  = at_or_after[ENTRIES-1];
   assign full     = slots[ENTRIES-1].valid;
   assign removing = fire && any_hit && ((cmd_ff.op == OP_LEAVE) || (cmd_ff.op == OP_SEAT));

   assign ctl.cmd     = cmd_ff;
   assign ctl.join_en = fire && (cmd_ff.op == OP_JOIN) && !any_hit && !full;

   // Row of cells; each takes its younger neighbor on a shift.
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      slot_type upper;
      logic     lower_valid;

      if (i == ENTRIES - 1) begin : g_top
         assign upper = '0;
      end else begin : g_mid
         assign upper = slots[i+1];
      end
      if (i == 0) begin : g_head
         assign lower_valid = 1'b1;
      end else begin : g_rest
         assign lower_valid = slots[i-1].valid;
      end

      ffwq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .shift       (removing && at_or_after[i]),
         .upper       (upper),
         .lower_valid (lower_valid),
         .slot        (slots[i]),
         .match       (match[i])
      );

      assign valid_vec[i] = slots[i].valid;
   end

   ffwq_prefix u_prefix (
      .match       (match),
      .slots       (slots),
      .at_or_after (at_or_after),
      .first       (first),
      .first_id    (first_id)
   );

   // Form the response word.
   always_comb begin
      rsp_id_in = '0;
      unique case (cmd_ff.op)
         OP_JOIN:  rsp_status_in = any_hit ? ST_DUP : (full ? ST_FULL : ST_JOINED);
         OP_LEAVE: rsp_status_in = any_hit ? ST_LEFT : ST_NOTFOUND;
         OP_SEAT: begin
            rsp_status_in = any_hit ? ST_SEATED : ST_NONEFITS;
            if (any_hit) begin
               rsp_id_in = 16'(first_id);
            end
         end
         default:  rsp_status_in = ST_NOTFOUND;
      endcase
   end

   // Capture request words, hold responses until taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req.valid && req.ready) begin
            cmd_valid_ff <= 1'b1;
            cmd_ff.op    <= req.opcode;
            cmd_ff.id    <= req.party_id[ID_W-1:0];
            cmd_ff.size  <= req.join_size;
            cmd_ff.cap   <= req.seat_cap;
         end else if (fire) begin
            cmd_valid_ff <= 1'b0;
         end
         if (fire) begin
            rsp_valid_ff  <= 1'b1;
            rsp_status_ff <= rsp_status_in;
            rsp_id_ff     <= rsp_id_in;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req.ready     = !cmd_valid_ff;
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.status    = rsp_status_ff;
   assign rsp.seated_id = rsp_id_ff;

   // Entries stay packed toward cell 0.
   a_packed : assert property (@(posedge clock) disable iff (reset)
      ((valid_vec >> 1) & ~valid_vec) == '0)
      else $error("queue entries not packed");

   // At most one oldest hit is picked.
   a_first_onehot : assert property (@(posedge clock) disable iff (reset)
      $onehot0(first))
      else $error("more than one entry selected");

   // A removal frees exactly one entry.
   a_remove_one : assert property (@(posedge clock) disable iff (reset)
      removing |=> $countones(valid_vec) == $countones($past(valid_vec)) - 1)
      else $error("removal did not free one entry");

   // A successful join adds exactly one entry.
   a_join_one : assert property (@(posedge clock) disable iff (reset)
      ctl.join_en |=> $countones(valid_vec) == $countones($past(valid_vec)) + 1)
      else $error("join did not add one entry");

   // Nothing changes the queue unless a command executes.
   a_idle_hold : assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(valid_vec))
      else $error("queue changed without a command");

endmodule

>>> rtl/ffwq_cell.sv
// One queue entry: compares against the command and shifts or loads in place.
`timescale 1ns / 1ps

module ffwq_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  ffwq_pkg::cell_ctl_type ctl,
   input  logic                 shift,
   input  ffwq_pkg::slot_type   upper,
   input  logic                 lower_valid,
   output ffwq_pkg::slot_type   slot,
   output logic                 match
);
   import ffwq_pkg::*;

   slot_type slot_ff;
   logic     id_hit;
   logic     fits;

   // Compare this entry against the command.
   assign id_hit = slot_ff.valid && (slot_ff.id == ctl.cmd.id);
   assign fits   = slot_ff.valid && (slot_ff.size != 8'd0) && (slot_ff.size <= ctl.cmd.cap);

   always_comb begin
      unique case (ctl.cmd.op)
         OP_JOIN, OP_LEAVE: match = id_hit;
         OP_SEAT:           match = fits;
         default:           match = 1'b0;
      endcase
   end

   // Take the younger neighbor on removal, or append at the first free place.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
      end else if (shift) begin
         slot_ff <= upper;
      end else if (ctl.join_en && lower_valid && !slot_ff.valid) begin
         slot_ff.valid <= 1'b1;
         slot_ff.id    <= ctl.cmd.id;
         slot_ff.size  <= ctl.cmd.size;
      end
   end

   assign slot = slot_ff;

endmodule

>>> rtl/ffwq_prefix.sv
// Parallel-prefix search for the oldest matching entry and its id.
`timescale 1ns / 1ps

module ffwq_prefix (
   input  logic [ffwq_pkg::ENTRIES-1:0] match,
   input  ffwq_pkg::slot_type           slots [ffwq_pkg::ENTRIES],
   output logic [ffwq_pkg::ENTRIES-1:0] at_or_after,
   output logic [ffwq_pkg::ENTRIES-1:0] first,
   output logic [ffwq_pkg::ID_W-1:0]    first_id
);
   import ffwq_pkg::*;

   logic [ENTRIES-1:0] lvl [PFX_LEVELS+1];

   // Inclusive prefix OR over the row, log-depth.
   always_comb begin
      lvl[0] = match;
      for (int l = 0; l < PFX_LEVELS; l++) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (i >= (1 << l)) begin
               lvl[l+1][i] = lvl[l][i] | lvl[l][i - (1 << l)];
            end else begin
               lvl[l+1][i] = lvl[l][i];
            end
         end
      end
   end

   assign at_or_after = lvl[PFX_LEVELS];
   assign first       = at_or_after & ~(at_or_after << 1);

   // One-hot select of the oldest hit's id.
   always_comb begin
      first_id = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         first_id = first_id | (slots[i].id & {ID_W{first[i]}});
      end
   end

endmodule

>>> test/waitlist_checker.sv
// Response checker for the waitlist queue: keeps its own copy of the line and compares words.
`timescale 1ns / 1ps

module waitlist_checker (
   input  logic clock,
   input  logic reset,
   ffwq_req_if  req,
   ffwq_rsp_if  rsp,
   output int   mismatches,
   output int   outstanding
);
   import ffwq_pkg::*;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] seated_id;
   } seat_result_type;

   // Predicted line contents, packed with the oldest request at position 0.
   logic [ID_W-1:0] line_id   [ENTRIES];
   logic [7:0]      line_size [ENTRIES];
   int              line_len;

   // Responses predicted but not yet seen on the response channel.
   seat_result_type expected_rsp [$];
   int              error_count;

   assign mismatches = error_count;

   task automatic report_mismatch(input string msg);
      $display("%0t: mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic int find_in_line(input logic [ID_W-1:0] key);
      for (int i = 0; i < line_len; i++) begin
         if (line_id[i] == key) begin
            return i;
         end
      end
      return -1;
   endfunction

   // Drop the entry at pos and close the gap behind it.
   task automatic remove_from_line(input int pos);
      for (int i = pos; i + 1 < line_len; i++) begin
         line_id[i]   = line_id[i + 1];
         line_size[i] = line_size[i + 1];
      end
      line_len--;
   endtask

   // Apply one request word to the predicted line and work out its response.
   task automatic predict_rsp(input logic [1:0] op, input logic [15:0] pid,
                              input logic [7:0] psize, input logic [7:0] cap,
                              output seat_result_type res);
      logic [ID_W-1:0] key;
      int              hit;
      key           = pid[ID_W-1:0];
      hit           = -1;
      res.status    = ST_NOTFOUND;
      res.seated_id = '0;
      case (op)
         OP_JOIN: begin
            if (find_in_line(key) >= 0) begin
               res.status = ST_DUP;
            end else if (line_len >= ENTRIES) begin
               res.status = ST_FULL;
            end else begin
               line_id[line_len]   = key;
               line_size[line_len] = psize;
               line_len++;
               res.status = ST_JOINED;
            end
         end
         OP_LEAVE: begin
            hit = find_in_line(key);
            if (hit >= 0) begin
               remove_from_line(hit);
               res.status = ST_LEFT;
            end
         end
         OP_SEAT: begin
            res.status = ST_NONEFITS;
            // Oldest request whose size is from 1 up to the capacity wins.
            for (int i = 0; i < line_len; i++) begin
               if (hit < 0 && line_size[i] >= 8'd1 && line_size[i] <= cap) begin
                  hit = i;
               end
            end
            if (hit >= 0) begin
               res.seated_id = 16'(line_id[hit]);
               remove_from_line(hit);
               res.status = ST_SEATED;
            end
         end
         default: ;
      endcase
   endtask

   // Sample both channels at each edge: check accepted responses, predict accepted requests.
   always @(posedge clock) begin
      seat_result_type want;
      seat_result_type got;
      if (reset) begin
         line_len    = 0;
         error_count = 0;
         expected_rsp.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch($sformatf("response word with none expected: status %0d id %h",
                                         rsp.status, rsp.seated_id));
            end else begin
               want = expected_rsp.pop_front();
               if (rsp.status !== want.status) begin
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp.status, want.status));
               end
               if (rsp.seated_id !== want.seated_id) begin
                  report_mismatch($sformatf("seated_id %h, expected %h",
                                            rsp.seated_id, want.seated_id));
               end
            end
         end
         if (req.valid && req.ready) begin
            predict_rsp(req.opcode, req.party_id, req.join_size, req.seat_cap, got);
            expected_rsp = {expected_rsp, got};
         end
      end
      outstanding <= expected_rsp.size();
   end

endmodule

>>> test/tb.sv
// Testbench top for the waitlist queue: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb;
   import ffwq_pkg::*;

   // Opcode with no operation behind it.
   localparam logic [1:0] OP_NONE = 2'd3;

   // Operation mixes for the random part.
   localparam int MIX_FILL  = 0;
   localparam int MIX_DRAIN = 1;
   localparam int MIX_EVEN  = 2;

   localparam int PHASE_ITEMS = 484;

   logic clock;
   logic reset;
   int   send_idle_pct   = 0;
   int   ready_stall_pct = 0;
   int   mismatches;
   int   outstanding;
   int   drain_wait;
   int   mix;

   ffwq_req_if req_bus ();
   ffwq_rsp_if rsp_bus ();

   first_fit_waitlist_queue u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   waitlist_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop in case the queue hangs.
   initial begin
      #10_000_000;
      $display("tb failed");
      $finish;
   end

   // Stall the response channel at the current rate.
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= ready_stall_pct);
   end

   // Present one request word, idling first at the current rate, and hold it until taken.
   task automatic send_word(input logic [1:0] op, input logic [15:0] pid,
                            input logic [7:0] psize, input logic [7:0] cap);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_bus.valid     <= 1'b1;
      req_bus.opcode    <= op;
      req_bus.party_id  <= pid;
      req_bus.join_size <= psize;
      req_bus.seat_cap  <= cap;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Mostly ids from a small pool so duplicates and leave hits are common.
   function automatic logic [15:0] pick_id();
      if ($urandom_range(0, 99) < 10) begin
         return 16'($urandom_range(0, 65535));
      end
      return 16'($urandom_range(0, 159) * 40503);
   endfunction

   task automatic send_random_word(input int op_mix);
      int         r;
      logic [1:0] op;
      logic [7:0] psize;
      logic [7:0] cap;
      r = $urandom_range(0, 99);
      case (op_mix)
         MIX_FILL:  op = (r < 85) ? OP_JOIN : (r < 90) ? OP_LEAVE : (r < 95) ? OP_SEAT : OP_NONE;
         MIX_DRAIN: op = (r < 20) ? OP_JOIN : (r < 60) ? OP_LEAVE : (r < 95) ? OP_SEAT : OP_NONE;
         default:   op = (r < 40) ? OP_JOIN : (r < 65) ? OP_LEAVE : (r < 95) ? OP_SEAT : OP_NONE;
      endcase
      r = $urandom_range(0, 99);
      psize = (r < 3) ? 8'd0 : (r < 50) ? 8'($urandom_range(1, 16)) : 8'($urandom_range(1, 255));
      r = $urandom_range(0, 99);
      cap = (r < 5) ? 8'd0 : (r < 15) ? 8'd255 :
            (r < 55) ? 8'($urandom_range(1, 32)) : 8'($urandom_range(0, 255));
      send_word(op, pick_id(), psize, cap);
   endtask

   initial begin
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.opcode    <= OP_JOIN;
      req_bus.party_id  <= '0;
      req_bus.join_size <= '0;
      req_bus.seat_cap  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Empty queue: seat, leave and the unused opcode all miss.
      send_word(OP_SEAT,  16'h0000, 8'd1,   8'd255);
      send_word(OP_LEAVE, 16'h0000, 8'd1,   8'd0);
      send_word(OP_NONE,  16'hFFFF, 8'd255, 8'd255);
      // Extreme ids and sizes, a duplicate, and a size-zero request.
      send_word(OP_JOIN,  16'h0000, 8'd1,   8'd0);
      send_word(OP_JOIN,  16'hFFFF, 8'd255, 8'd0);
      send_word(OP_JOIN,  16'h0000, 8'd7,   8'd0);
      send_word(OP_JOIN,  16'h1234, 8'd0,   8'd255);
      send_word(OP_NONE,  16'h1234, 8'd0,   8'd255);
      // Zero capacity never fits; full capacity takes the oldest.
      send_word(OP_SEAT,  16'h0000, 8'd0,   8'd0);
      send_word(OP_SEAT,  16'h0000, 8'd0,   8'd255);
      send_word(OP_SEAT,  16'h0000, 8'd0,   8'd254);
      send_word(OP_SEAT,  16'h0000, 8'd0,   8'd255);
      // Size-zero request leaves only by id.
      send_word(OP_SEAT,  16'h0000, 8'd0,   8'd255);
      send_word(OP_LEAVE, 16'h1234, 8'd0,   8'd0);
      send_word(OP_LEAVE, 16'h1234, 8'd0,   8'd0);
      send_word(OP_JOIN,  16'hA5A5, 8'd2,   8'd0);
      send_word(OP_JOIN,  16'h5A5A, 8'd1,   8'd0);
      send_word(OP_SEAT,  16'h0000, 8'd0,   8'd1);
      send_word(OP_LEAVE, 16'hA5A5, 8'd0,   8'd0);

      // Random part, one phase per idling pattern.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 0;  ready_stall_pct = 0;  end
            1:       begin send_idle_pct = 75; ready_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  ready_stall_pct = 75; end
            default: begin send_idle_pct = 16; ready_stall_pct = 16; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 64 == 0) begin
               mix = $urandom_range(MIX_FILL, MIX_EVEN);
            end
            send_random_word(mix);
         end
      end
      req_bus.valid <= 1'b0;

      // Wait for the last responses, then wait on for stray response words.
      drain_wait = 0;
      while (outstanding != 0 && drain_wait < 5000) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (10) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
